/* rtl/nqts_pkg.sv */
// ----------------------------------------------------------------------------
// nqts_pkg: note queue tone sequencer shared definitions
// Request codes, field widths, reset constants and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package nqts_pkg;

  localparam int HZ_W          = 16;
  localparam int MS_W          = 16;
  localparam int NOTE_W        = HZ_W + MS_W;  // hz in upper half, ms in lower
  localparam int QCOUNT_W      = 8;
  localparam int DEF_QUEUE_DEPTH = 128;

  localparam logic [MS_W-1:0] CUR_MS_RESET = MS_W'(50);
  localparam logic [MS_W-1:0] ELAPSED_MAX  = '1;

  typedef logic [1:0] req_t;
  localparam req_t REQ_TICK   = 2'd0;
  localparam req_t REQ_APPEND = 2'd1;
  localparam req_t REQ_INSERT = 2'd2;
  localparam req_t REQ_CLEAR  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic latch;   // capture the input word
    logic exec;    // run the request against queue state
    logic load;    // head note read data is valid, start it
    logic finish;  // capture the result word
  } nqts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_load;  // tick starts a note, wait for the store read
  } nqts_sts_t;

endpackage

/* rtl/note_queue_tone_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// note_queue_tone_sequencer_unit: note queue tone sequencer top level
// Queue of notes (hz, ms) in a ring buffer, advanced by millisecond ticks.
// ----------------------------------------------------------------------------
// Sequencing: an accepted word is latched, then executed in EXEC once the result
//   slot is free; a tick that starts a note adds LOAD for the registered store read.
// Flow: one word in flight, the next accepted while the last result is still
//   waiting; EXEC stalls while an unread result holds the result slot.
// Reset (rst_n, sync, active low): empty queue, silent, speaker enabled,
//   current duration 50 ms. Note store is not cleared, no clearing pass.
module note_queue_tone_sequencer_unit
  import nqts_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH  // 2 .. 1024 notes
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] note_hz, [31:16] note_ms
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] tone_hz, [16] sound_on, [17] playing,
                                  // [25:18] queue_count, [26] accepted, rest 0
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data // speaker_enable
);

  nqts_cmd_t cmd;
  nqts_sts_t sts;

  logic [HZ_W-1:0]     res_tone_hz;
  logic                res_sound_on;
  logic                res_playing;
  logic [QCOUNT_W-1:0] res_queue_count;
  logic                res_accepted;

  // controller: IDLE -> EXEC (-> LOAD on note start) -> IDLE
  nqts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: pointers, timer, note store, result register
  nqts_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_req          (in_tuser),
    .in_hz           (in_tdata[15:0]),
    .in_ms           (in_tdata[31:16]),
    .res_tone_hz     (res_tone_hz),
    .res_sound_on    (res_sound_on),
    .res_playing     (res_playing),
    .res_queue_count (res_queue_count),
    .res_accepted    (res_accepted)
  );

  // result word packing, high field first, zero fill to 32 bits
  assign out_tdata = {5'b0, res_accepted, res_queue_count, res_playing,
                      res_sound_on, res_tone_hz};

endmodule

/* rtl/nqts_ram.sv */
// ----------------------------------------------------------------------------
// nqts_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nqts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/nqts_ctrl.sv */
// ----------------------------------------------------------------------------
// nqts_ctrl: sequencer controller
// Steps each word through execute and optional head-note load, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module nqts_ctrl
  import nqts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  nqts_sts_t sts,
  output nqts_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       slot_free;

  assign slot_free  = !out_vld_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;

  always_comb begin
    cmd.latch  = in_tvalid && in_tready;
    cmd.exec   = (state_r == ST_EXEC) && slot_free;
    cmd.load   = (state_r == ST_LOAD);
    cmd.finish = (cmd.exec && !sts.need_load) || cmd.load;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.latch) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.exec) state_nxt = sts.need_load ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

/* rtl/nqts_dp.sv */
// ----------------------------------------------------------------------------
// nqts_dp: sequencer datapath
// Queue pointers, note timer, note store and the result register.
// ----------------------------------------------------------------------------
module nqts_dp
  import nqts_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nqts_cmd_t           cmd,
  output nqts_sts_t           sts,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  req_t                in_req,
  input  logic [HZ_W-1:0]     in_hz,
  input  logic [MS_W-1:0]     in_ms,
  output logic [HZ_W-1:0]     res_tone_hz,
  output logic                res_sound_on,
  output logic                res_playing,
  output logic [QCOUNT_W-1:0] res_queue_count,
  output logic                res_accepted
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int QW    = (CNT_W > QCOUNT_W) ? CNT_W : QCOUNT_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(QUEUE_DEPTH);
  localparam logic [QW-1:0]    QC_MAX   = QW'((1 << QCOUNT_W) - 1);

  // latched request
  req_t            req_r;
  logic [HZ_W-1:0] hz_r;
  logic [MS_W-1:0] ms_r;

  // queue and timer state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             playing_r, playing_nxt;
  logic             muted_r, muted_nxt;
  logic [HZ_W-1:0]  cur_hz_r, cur_hz_nxt;
  logic [MS_W-1:0]  cur_ms_r, cur_ms_nxt;
  logic [MS_W-1:0]  elapsed_r, elapsed_nxt;
  logic             spk_r;
  logic             acc_nxt;

  // store access
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [NOTE_W-1:0] ram_rdata;

  logic [IDX_W-1:0]  head_inc, head_dec, tail;
  logic [SUM_W-1:0]  tail_sum;
  logic [MS_W-1:0]   el_tick;
  logic              full;
  logic [QW-1:0]     cnt_ext;

  assign head_inc = (head_r == IDX_LAST) ? '0 : head_r + IDX_W'(1);
  assign head_dec = (head_r == '0) ? IDX_LAST : head_r - IDX_W'(1);
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail     = (tail_sum >= SUM_WRAP) ? IDX_W'(tail_sum - SUM_WRAP) : IDX_W'(tail_sum);
  assign full     = (count_r == CNT_FULL);
  assign el_tick  = (playing_r && elapsed_r != ELAPSED_MAX) ? elapsed_r + MS_W'(1) : elapsed_r;

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    playing_nxt   = playing_r;
    muted_nxt     = muted_r;
    cur_hz_nxt    = cur_hz_r;
    cur_ms_nxt    = cur_ms_r;
    elapsed_nxt   = elapsed_r;
    acc_nxt       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = tail;
    ram_raddr     = head_r;
    sts.need_load = 1'b0;

    if (cmd.exec) begin
      case (req_r)
        REQ_TICK: begin
          elapsed_nxt = el_tick;
          if (!spk_r) begin
            muted_nxt = 1'b1;
          end else if (count_r != '0) begin
            if (!playing_r) begin
              sts.need_load = 1'b1;
            end else if (el_tick >= cur_ms_r) begin
              head_nxt  = head_inc;
              count_nxt = count_r - CNT_W'(1);
              if (count_r != CNT_W'(1)) begin
                sts.need_load = 1'b1;
                ram_raddr     = head_inc;
              end else begin
                cur_hz_nxt  = '0;
                playing_nxt = 1'b0;
              end
            end
          end
        end
        REQ_APPEND: begin
          if (!full) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            acc_nxt   = 1'b1;
          end
        end
        REQ_INSERT: begin
          if (!full) begin
            ram_we    = 1'b1;
            ram_waddr = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + CNT_W'(1);
            acc_nxt   = 1'b1;
          end
        end
        default: begin  // clear also stops playback
          count_nxt   = '0;
          playing_nxt = 1'b0;
          cur_hz_nxt  = '0;
          elapsed_nxt = '0;
        end
      endcase
    end

    if (cmd.load) begin
      cur_hz_nxt  = ram_rdata[NOTE_W-1:MS_W];
      cur_ms_nxt  = ram_rdata[MS_W-1:0];
      elapsed_nxt = '0;
      playing_nxt = 1'b1;
      muted_nxt   = 1'b0;
    end
  end

  assign ram_re  = sts.need_load;
  assign cnt_ext = QW'(count_nxt);

  nqts_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data ({hz_r, ms_r}),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      playing_r <= 1'b0;
      muted_r   <= 1'b0;
      cur_hz_r  <= '0;
      cur_ms_r  <= CUR_MS_RESET;
      elapsed_r <= '0;
      spk_r     <= 1'b1;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      playing_r <= playing_nxt;
      muted_r   <= muted_nxt;
      cur_hz_r  <= cur_hz_nxt;
      cur_ms_r  <= cur_ms_nxt;
      elapsed_r <= elapsed_nxt;
      if (cfg_wr_en) spk_r <= cfg_wr_data;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req;
      hz_r  <= in_hz;
      ms_r  <= in_ms;
    end
    if (cmd.finish) begin
      res_tone_hz     <= cur_hz_nxt;
      res_sound_on    <= playing_nxt && !muted_nxt && (cur_hz_nxt != '0);
      res_playing     <= playing_nxt;
      res_queue_count <= (cnt_ext > QC_MAX) ? '1 : cnt_ext[QCOUNT_W-1:0];
      res_accepted    <= acc_nxt;
    end
  end

endmodule

/* rtl/nqts_checker.sv */
// ----------------------------------------------------------------------------
// nqts_checker: port-level checks for the sequencer
// Watches handshakes and result word consistency at the top level ports.
// ----------------------------------------------------------------------------
module nqts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  // one word in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in flight");

  // audible only while a nonzero note is playing
  a_sound_playing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[17] && (out_tdata[15:0] != 16'd0))
    else $error("sound_on without a playing nonzero tone");

  // a stored note leaves the queue nonempty
  a_acc_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> (out_tdata[25:18] != 8'd0))
    else $error("accepted with empty queue");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:27] == 5'd0))
    else $error("nonzero padding in result word");

endmodule

bind note_queue_tone_sequencer_unit nqts_checker u_nqts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* dv/note_queue_tone_sequencer_unit_test.sv */
// ----------------------------------------------------------------------------
// note_queue_tone_sequencer_unit_test: self-checking bench for the sequencer
// Drives tick / append / insert / clear words, predicts every result word
// with a local model of the note queue and compares field by field. Runs a
// short directed opener, then random phases with different idle mixes,
// speaker settings and one long receiver hold-off.
// ----------------------------------------------------------------------------
module note_queue_tone_sequencer_unit_test;
  import nqts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH    = DEF_QUEUE_DEPTH;
  localparam int WATCHDOG_LIMIT = 3000;  // longest legal quiet stretch is the hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;     // margin after the last result word before the next phase
  localparam int MAX_REPORTS    = 10;

  // One request word as the sender sees it.
  typedef struct {
    req_t        req;
    logic [15:0] hz;
    logic [15:0] ms;
  } note_req_t;

  // Result word, same layout as out_tdata (lowest field last here).
  typedef struct packed {
    logic [4:0]  pad;
    logic        accepted;
    logic [7:0]  queue_count;
    logic        playing;
    logic        sound_on;
    logic [15:0] tone_hz;
  } tone_word_t;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = REQ_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b1;

  note_queue_tone_sequencer_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local model of the sequencer state
  // --------------------------------------------------------------------------
  logic [31:0] note_mem [QUEUE_DEPTH];  // hz in [31:16], ms in [15:0]
  int unsigned head_idx   = 0;
  int unsigned note_cnt   = 0;
  bit          is_playing = 1'b0;
  bit          is_muted   = 1'b0;
  logic [15:0] cur_hz     = '0;
  logic [15:0] cur_ms     = CUR_MS_RESET;
  logic [15:0] elapsed    = '0;
  bit          spk_en     = 1'b1;  // mirror of speaker_enable

  // Bench bookkeeping
  note_req_t   pending_reqs[$];     // words waiting to be offered
  tone_word_t  expected_tones[$];   // predictions waiting for their result word
  note_req_t   offer;
  bit          in_fire      = 1'b0; // offered word taken at the last rising edge
  bit          hold_off     = 1'b0; // receiver forced off (pressure test)
  int          in_idle_pct  = 0;
  int          out_stall_pct = 0;
  int          quiet_cycles = 0;
  int          mismatches   = 0;

  function automatic void start_head_note();
    cur_hz     = note_mem[head_idx][31:16];
    cur_ms     = note_mem[head_idx][15:0];
    elapsed    = '0;
    is_playing = 1'b1;
    is_muted   = 1'b0;
  endfunction

  // One millisecond: time the note, then start or advance if the speaker allows.
  function automatic void ms_tick();
    if (is_playing && elapsed != ELAPSED_MAX) elapsed++;
    if (!spk_en) begin
      is_muted = 1'b1;
      return;
    end
    if (note_cnt == 0) return;
    if (!is_playing) begin
      start_head_note();
    end else if (elapsed >= cur_ms) begin
      // the head entry goes, even if it was inserted after this note started
      head_idx = (head_idx + 1) % QUEUE_DEPTH;
      note_cnt--;
      if (note_cnt > 0) begin
        start_head_note();
      end else begin
        cur_hz     = '0;
        is_playing = 1'b0;
      end
    end
  endfunction

  function automatic tone_word_t predict_tone(req_t req, logic [15:0] hz, logic [15:0] ms);
    tone_word_t res;
    bit         stored;
    stored = 1'b0;
    case (req)
      REQ_TICK: begin
        ms_tick();
      end
      REQ_APPEND: begin
        if (note_cnt < QUEUE_DEPTH) begin
          note_mem[(head_idx + note_cnt) % QUEUE_DEPTH] = {hz, ms};
          note_cnt++;
          stored = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (note_cnt < QUEUE_DEPTH) begin
          head_idx = (head_idx + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          note_mem[head_idx] = {hz, ms};
          note_cnt++;
          stored = 1'b1;
        end
      end
      default: begin
        // clear: head index and current duration survive
        note_cnt   = 0;
        is_playing = 1'b0;
        cur_hz     = '0;
        elapsed    = '0;
      end
    endcase
    res             = '0;
    res.tone_hz     = cur_hz;
    res.sound_on    = is_playing && !is_muted && cur_hz != 0;
    res.playing     = is_playing;
    res.queue_count = (note_cnt > 255) ? 8'd255 : note_cnt[7:0];
    res.accepted    = stored;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: changes at the falling edge, pulls from pending_reqs
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      in_fire = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        offer = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= offer.req;
        in_tdata  <= {offer.ms, offer.hz};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && !hold_off && ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Accepted input word: run the model, queue the expected result.
  always @(posedge clk) begin
    tone_word_t exp_new;
    if (rst_n && in_tvalid && in_tready) begin
      exp_new = predict_tone(req_t'(in_tuser), in_tdata[15:0], in_tdata[31:16]);
      expected_tones = {expected_tones, exp_new};
      in_fire = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every accepted result word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    tone_word_t got, exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      got = tone_word_t'(out_tdata);
      if (expected_tones.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result word %h", $realtime, out_tdata);
      end else begin
        exp_w = expected_tones.pop_front();
        if (got.tone_hz !== exp_w.tone_hz || got.sound_on !== exp_w.sound_on ||
            got.playing !== exp_w.playing || got.queue_count !== exp_w.queue_count ||
            got.accepted !== exp_w.accepted || got.pad !== exp_w.pad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result mismatch exp hz=%0d snd=%0b ply=%0b cnt=%0d acc=%0b pad=%0h",
                     $realtime, exp_w.tone_hz, exp_w.sound_on, exp_w.playing,
                     exp_w.queue_count, exp_w.accepted, exp_w.pad);
          if (mismatches <= MAX_REPORTS)
            $display("%0t:                 got hz=%0d snd=%0b ply=%0b cnt=%0d acc=%0b pad=%0h",
                     $realtime, got.tone_hz, got.sound_on, got.playing,
                     got.queue_count, got.accepted, got.pad);
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_item(req_t req, logic [15:0] hz, logic [15:0] ms);
    note_req_t r;
    r.req = req;
    r.hz  = hz;
    r.ms  = ms;
    pending_reqs = {pending_reqs, r};
  endfunction

  // Ticks carry random junk in the ignored note fields.
  function automatic void add_tick();
    add_item(REQ_TICK, 16'($urandom), 16'($urandom));
  endfunction

  function automatic logic [15:0] rand_hz();
    return ($urandom_range(0, 99) < 6) ? 16'd0 : 16'($urandom);
  endfunction

  // Mostly short notes so the queue keeps moving, now and then a long one.
  function automatic logic [15:0] rand_ms();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 16'($urandom_range(0, 3));
    if (pick < 92) return 16'($urandom_range(4, 40));
    return 16'($urandom);
  endfunction

  function automatic void queue_random(int n_items);
    int pick;
    while (pending_reqs.size() < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // short tune, then let it play out
        repeat ($urandom_range(1, 6)) add_item(REQ_APPEND, rand_hz(), rand_ms());
        repeat ($urandom_range(1, 24)) add_tick();
      end else if (pick < 60) begin
        // notes jumped to the head while something may be playing
        repeat ($urandom_range(1, 3)) begin
          add_item(REQ_INSERT, rand_hz(), rand_ms());
          repeat ($urandom_range(0, 4)) add_tick();
        end
      end else if (pick < 64) begin
        // push past capacity
        repeat ($urandom_range(QUEUE_DEPTH - 8, QUEUE_DEPTH + 12))
          add_item($urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT, rand_hz(), rand_ms());
      end else if (pick < 85) begin
        repeat ($urandom_range(4, 30)) add_tick();
      end else if (pick < 92) begin
        add_item(REQ_CLEAR, 16'($urandom), 16'($urandom));
      end else begin
        // noise: any request, any field values
        repeat ($urandom_range(1, 5))
          add_item(req_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
      end
    end
  endfunction

  // Wait for every word offered and every result back, then let the DUT settle.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_tones.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while idle; the model follows at once since nothing is in flight.
  task automatic write_speaker(bit on);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    spk_en       = on;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(int in_pct, int out_pct, bit spk, int n_items);
    drain();
    write_speaker(spk);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    queue_random(n_items);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    write_speaker(1'b1);

    // Directed opener, speaker on
    add_tick();                             // tick on an empty queue
    add_item(REQ_APPEND, 16'hFFFF, 16'd0);  // top frequency, zero duration
    add_item(REQ_APPEND, 16'd0, 16'd1);     // zero frequency: timed but silent
    add_item(REQ_INSERT, 16'd440, 16'd2);   // insert while idle, head wraps back
    add_tick();                             // starts the head note
    add_item(REQ_INSERT, 16'd1000, 16'hFFFF); // insert while playing
    repeat (8) add_tick();                  // inserted head removed on expiry, rest plays out
    add_item(REQ_APPEND, 16'd1234, 16'd3);
    add_tick();
    add_item(REQ_CLEAR, 16'hFFFF, 16'hFFFF); // clear ends playback too
    add_tick();
    add_item(REQ_APPEND, 16'd880, 16'd300);
    add_tick();                             // leaves a long note playing
    drain();

    // Speaker off mid-note: muted, still timed, nothing starts or advances
    write_speaker(1'b0);
    add_tick();
    add_item(REQ_APPEND, 16'd660, 16'd1);
    add_tick();
    add_tick();
    drain();

    // Random phases: idle mix and speaker setting vary
    run_phase(0, 0, 1'b1, 150);

    // speaker off: nothing advances, so start by filling the queue to overflow
    drain();
    write_speaker(1'b0);
    repeat (QUEUE_DEPTH + 4) add_item(REQ_APPEND, rand_hz(), rand_ms());
    in_idle_pct   = 47;
    out_stall_pct = 0;
    queue_random(150);
    drain();

    run_phase(0, 47, 1'b1, 150);
    run_phase(33, 33, 1'b0, 80);
    run_phase(33, 33, 1'b1, 80);

    // Pressure: receiver held off for a long stretch while the sender keeps
    // offering, so the DUT fills up and backs up its input.
    drain();
    write_speaker(1'b1);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    queue_random(110);
    drain();

    // leftover predictions count as failures
    mismatches += expected_tones.size();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/nqts_pkg.sv
rtl/nqts_ram.sv
rtl/nqts_ctrl.sv
rtl/nqts_dp.sv
rtl/note_queue_tone_sequencer_unit.sv
rtl/nqts_checker.sv
dv/note_queue_tone_sequencer_unit_test.sv
